### design/integer_to_radix_ascii_assert.svh
// ----------------------------------------------------------------------------
// integer_to_radix_ascii assertion macros
// Concurrent assertion shorthands for the radix text converter.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_ASCII_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IRA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define IRA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/ira_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ira_pkg
// Shared constants, types and the digit-to-character map of the converter.
// ----------------------------------------------------------------------------
package ira_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int RADIX_W            = 6;
   localparam int CHAR_W             = 7;

   localparam logic [RADIX_W-1:0] RADIX_RESET    = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN      = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX      = 6'd36;
   localparam logic [RADIX_W-1:0] DECIMAL_DIGITS = 6'd10;
   localparam logic [RADIX_W-1:0] DIGIT_LIMIT    = 6'd36;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_LOW_A = 7'h61;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_FETCH,
      ST_EMIT
   } ira_state_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic q_nonzero;
   } ira_div_status_type;

   // 0-9 then a-z; anything past 35 maps to '0'
   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [RADIX_W-1:0] letter;
      letter = d - DECIMAL_DIGITS;
      if (d < DECIMAL_DIGITS) begin
         return CHAR_ZERO + CHAR_W'(d);
      end else if (d < DIGIT_LIMIT) begin
         return CHAR_LOW_A + CHAR_W'(letter);
      end else begin
         return CHAR_ZERO;
      end
   endfunction

endpackage
`default_nettype wire

### design/integer_to_radix_ascii.sv
// Each digit takes a full divider pass; the text then goes out as an optional
//   minus sign followed by a store read and a load per digit, and the output
//   can stall the sign and every load.
// Throughput: one number at a time; the next is taken once the output
//   register is free, as the final character transfers or later.
// Reset: synchronous, clears control state and sets the base to 10; no pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// Signed integer to text in a base from 2 to 36, one character per transfer.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii #(
   parameter int VALUE_BITS = ira_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // number input
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [VALUE_BITS-1:0]  req_number,
   // character output
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [ira_pkg::CHAR_W-1:0]         rsp_character,
   output logic                               rsp_last,
   output logic                               rsp_bad_base,
   // base register write
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ira_pkg::RADIX_W-1:0]   csr_radix
);
   import ira_pkg::*;

   localparam int CNT_W = $clog2(VALUE_BITS + 1);
   localparam int IDX_W = $clog2(VALUE_BITS);

   // state and registers
   ira_state_type       state_ff, state_in;
   logic [RADIX_W-1:0]  radix_ff;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;       // digits held
   logic                neg_ff, neg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_bad_ff, rsp_bad_in;
   logic                load_rsp;

   // digit store, least significant digit at index 0
   logic [RADIX_W-1:0]  digit_store [VALUE_BITS];
   logic [RADIX_W-1:0]  rd_data_ff;
   logic [CNT_W-1:0]    cnt_dec;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;

   // divider link
   logic                   div_start;
   logic [VALUE_BITS-1:0]  div_dividend;
   logic [VALUE_BITS-1:0]  div_quotient;
   logic [RADIX_W-1:0]     div_rem;
   ira_div_status_type     div_status;

   logic [VALUE_BITS-1:0]  num_u;
   logic                   num_neg;
   logic [VALUE_BITS-1:0]  num_mag;
   logic                   base_bad;
   logic                   out_free;

   // magnitude held unsigned so the most negative value converts exactly
   assign num_u    = $unsigned(req_number);
   assign num_neg  = num_u[VALUE_BITS-1];
   assign num_mag  = num_neg ? (~num_u + VALUE_BITS'(1)) : num_u;
   assign base_bad = (radix_ff < RADIX_MIN) || (radix_ff > RADIX_MAX);

   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // first pass divides the magnitude, later passes the previous quotient
   assign div_dividend = (state_ff == ST_IDLE) ? num_mag : div_quotient;

   assign cnt_dec = cnt_ff - CNT_W'(1);
   assign rd_addr = cnt_dec[IDX_W-1:0];

   ira_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (radix_ff),
      .quotient  (div_quotient),
      .remainder (div_rem),
      .status    (div_status)
   );

   // next state and datapath control
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      neg_in      = neg_ff;
      req_ready   = 1'b0;
      div_start   = 1'b0;
      wr_en       = 1'b0;
      load_rsp    = 1'b0;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      rsp_bad_in  = rsp_bad_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               if (base_bad) begin
                  // single NUL with bad base flag; digit state untouched
                  load_rsp    = 1'b1;
                  rsp_char_in = CHAR_NUL;
                  rsp_last_in = 1'b1;
                  rsp_bad_in  = 1'b1;
               end else begin
                  neg_in    = num_neg;
                  cnt_in    = '0;
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
               if (div_status.q_nonzero && (cnt_ff != CNT_W'(VALUE_BITS - 1))) begin
                  div_start = 1'b1;
               end else begin
                  state_in = neg_ff ? ST_SIGN : ST_FETCH;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               load_rsp    = 1'b1;
               rsp_char_in = CHAR_MINUS;
               rsp_last_in = 1'b0;
               rsp_bad_in  = 1'b0;
               state_in    = ST_FETCH;
            end
         end
         ST_FETCH: begin
            // digit store read settles into rd_data_ff
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               load_rsp    = 1'b1;
               rsp_char_in = digit_char(rd_data_ff);
               rsp_last_in = (cnt_ff == CNT_W'(1));
               rsp_bad_in  = 1'b0;
               cnt_in      = cnt_dec;
               state_in    = (cnt_ff == CNT_W'(1)) ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         cnt_ff       <= '0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            radix_ff <= csr_radix;
         end
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_char_ff <= rsp_char_in;
         rsp_last_ff <= rsp_last_in;
         rsp_bad_ff  <= rsp_bad_in;
      end
   end

   // digit store: written as remainders arrive, read one digit behind
   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_store[cnt_ff[IDX_W-1:0]] <= div_rem;
      end
      rd_data_ff <= digit_store[rd_addr];
   end

   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_bad_base  = rsp_bad_ff;

   // checks
`include "integer_to_radix_ascii_assert.svh"

   `IRA_ASSERT_IMPL(a_bad_base_single, clock, reset, rsp_valid && rsp_bad_base, rsp_last && (rsp_character == CHAR_NUL), "bad base result not a lone NUL")
   `IRA_ASSERT_IMPL(a_start_when_free, clock, reset, div_start, !div_status.busy, "divider restarted while busy")
   `IRA_ASSERT_IMPL(a_emit_has_digit, clock, reset, (state_ff == ST_EMIT) || (state_ff == ST_FETCH), cnt_ff != '0, "emitting with empty digit store")
   `IRA_ASSERT_NEXT(a_done_bounded, clock, reset, (state_ff == ST_DIVIDE) && div_status.done, cnt_ff <= CNT_W'(VALUE_BITS), "digit count exceeds store depth")

endmodule
`default_nettype wire

### design/ira_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ira_divider
// Bit-serial restoring divider: one quotient bit per cycle by a 6-bit base.
// ----------------------------------------------------------------------------
module ira_divider #(
   parameter int VALUE_BITS = ira_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [VALUE_BITS-1:0]        dividend,
   input  wire logic [ira_pkg::RADIX_W-1:0]  divisor,
   output logic      [VALUE_BITS-1:0]        quotient,
   output logic      [ira_pkg::RADIX_W-1:0]  remainder,
   output ira_pkg::ira_div_status_type       status
);
   import ira_pkg::*;

   localparam int CNT_W = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0] quo_ff;
   logic [RADIX_W-1:0]    rem_ff;
   logic [CNT_W-1:0]      step_ff;
   logic                  done_ff;
   logic                  nz_ff;

   logic [RADIX_W:0]      partial;
   logic [RADIX_W:0]      diff;
   logic                  fits;
   logic [RADIX_W-1:0]    rem_in;

   // shift next dividend bit into the partial remainder, subtract if it fits
   always_comb begin
      partial = {rem_ff, quo_ff[VALUE_BITS-1]};
      fits    = partial >= {1'b0, divisor};
      diff    = partial - {1'b0, divisor};
      rem_in  = fits ? diff[RADIX_W-1:0] : partial[RADIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
         nz_ff   <= 1'b0;
      end else if (start) begin
         step_ff <= CNT_W'(VALUE_BITS);
         done_ff <= 1'b0;
         nz_ff   <= 1'b0;
      end else if (step_ff != '0) begin
         step_ff <= step_ff - CNT_W'(1);
         done_ff <= (step_ff == CNT_W'(1));
         nz_ff   <= nz_ff | fits;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (step_ff != '0) begin
         quo_ff <= {quo_ff[VALUE_BITS-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign quotient         = quo_ff;
   assign remainder        = rem_ff;
   assign status.busy      = (step_ff != '0);
   assign status.done      = done_ff;
   assign status.q_nonzero = nz_ff;

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - integer_to_radix_ascii testbench
// Drives signed numbers through the converter under changing bases and checks
// every character transfer against a predicted text stream, with random idling
// on both sides, a long output stall and a mid-run drain of the sender.
// ----------------------------------------------------------------------------
module tb;
   import ira_pkg::*;

   // Worst case is base 2 with 32 digits.
   localparam int DRAIN_TAIL  = 1200;
   // Longest quiet stretch: a full base-2 conversion plus the output stall.
   localparam int STALL_LIMIT = 20000;
   localparam int NUM_W       = VALUE_BITS_DEFAULT;

   // One character transfer as seen on the output channel
   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
      logic              bad_base;
   } text_char_type;

   // Every block input starts at a known value
   logic                     clock         = 1'b0;
   logic                     reset         = 1'b1;
   logic                     req_valid     = 1'b0;
   logic                     req_ready;
   logic signed [NUM_W-1:0]  req_number    = '0;
   logic                     rsp_valid;
   logic                     rsp_ready     = 1'b0;
   logic [CHAR_W-1:0]        rsp_character;
   logic                     rsp_last;
   logic                     rsp_bad_base;
   logic                     csr_valid     = 1'b0;
   logic                     csr_ready;
   logic [RADIX_W-1:0]       csr_radix     = '0;

   // Predictor state: the base the block should be using right now
   logic [RADIX_W-1:0]       radix_setting = RADIX_RESET;
   text_char_type            expected_text[$];

   int                       fault_count   = 0;
   int                       send_idle_pct = 0;
   int                       recv_idle_pct = 0;
   int                       rsp_hold_left = 0;
   int                       quiet_cycles  = 0;

   integer_to_radix_ascii uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_number    (req_number),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .rsp_bad_base  (rsp_bad_base),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_radix     (csr_radix)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Text predictor
   // ------------------------------------------------------------------------

   // Appends the characters one accepted number should produce under the
   // current base. Magnitude is held unsigned, so the most negative value
   // converts without overflow.
   function automatic void predict_text(input logic signed [NUM_W-1:0] value);
      logic [NUM_W-1:0]   magnitude;
      logic [NUM_W-1:0]   base;
      logic [RADIX_W-1:0] digits[$];
      logic [RADIX_W-1:0] d;
      text_char_type      ch;
      int                 i;
      if (radix_setting < RADIX_MIN || radix_setting > RADIX_MAX) begin
         ch.character = CHAR_NUL;
         ch.last      = 1'b1;
         ch.bad_base  = 1'b1;
         expected_text.push_back(ch);
         return;
      end
      base      = NUM_W'(radix_setting);
      magnitude = value[NUM_W-1] ? (~value + 1'b1) : value;
      // least significant digit first; zero still yields one digit
      do begin
         digits.push_back(RADIX_W'(magnitude % base));
         magnitude = magnitude / base;
      end while (magnitude != 0);
      ch.bad_base = 1'b0;
      if (value[NUM_W-1]) begin
         ch.character = CHAR_MINUS;
         ch.last      = 1'b0;
         expected_text.push_back(ch);
      end
      for (i = digits.size() - 1; i >= 0; i--) begin
         d = digits[i];
         if (d < 10)
            ch.character = CHAR_ZERO + CHAR_W'(d);
         else
            ch.character = CHAR_LOW_A + CHAR_W'(d - 10);
         ch.last = (i == 0);
         expected_text.push_back(ch);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Mostly valid bases, with the limits favoured and the odd bad one
   function automatic logic [RADIX_W-1:0] pick_radix();
      logic [RADIX_W-1:0] r;
      case ($urandom_range(0, 9))
         0:       r = RADIX_MIN;
         1:       r = RADIX_MAX;
         2:       r = ($urandom_range(0, 2) == 0) ? RADIX_W'($urandom_range(0, 1))
                                                  : RADIX_W'($urandom_range(37, 63));
         default: r = RADIX_W'($urandom_range(2, 36));
      endcase
      return r;
   endfunction

   // Numbers spread over full-width, short, digit-boundary and extreme values
   function automatic logic signed [NUM_W-1:0] pick_number();
      logic [63:0]             power;
      logic [NUM_W-1:0]        raw;
      logic signed [NUM_W-1:0] value;
      power = 64'd1;
      raw   = $urandom;
      case ($urandom_range(0, 4))
         0: value = $signed(raw);
         1: value = $signed(raw) >>> $urandom_range(0, NUM_W - 1);
         2: begin
            // a power of the base, give or take one, so digit counts roll over
            if (radix_setting >= RADIX_MIN && radix_setting <= RADIX_MAX) begin
               repeat ($urandom_range(0, NUM_W - 1))
                  if (power * radix_setting <= 64'h7fff_ffff)
                     power = power * radix_setting;
            end
            raw   = power[NUM_W-1:0] + $urandom_range(0, 2) - 1;
            value = $urandom_range(0, 1) ? -$signed(raw) : $signed(raw);
         end
         3: begin
            case ($urandom_range(0, 3))
               0:       value = 32'sh8000_0000;
               1:       value = 32'sh7fff_ffff;
               2:       value = -32'sd1;
               default: value = '0;
            endcase
         end
         default: value = $urandom_range(0, 1) ? -$signed(NUM_W'($urandom_range(0, 40)))
                                               : $signed(NUM_W'($urandom_range(0, 40)));
      endcase
      return value;
   endfunction

   // Drops the input valid and waits until every predicted character has
   // been transferred. Always waits on the clock, even with nothing pending.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_text.size() != 0);
   endtask

   // One number transfer. Valid stays high afterwards so back-to-back numbers
   // never see valid dropped and raised in the same step; wait_drained or the
   // next idle gap lowers it.
   task automatic send_number(input logic signed [NUM_W-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_number <= value;
      do @(posedge clock); while (!req_ready);
      predict_text(value);
   endtask

   // Base register write, only ever with the block idle
   task automatic write_radix(input logic [RADIX_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_radix <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      radix_setting  = value;
   endtask

   // ------------------------------------------------------------------------
   // Output side: ready with random idling, or held off by a counted stall
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_ready     <= 1'b0;
         rsp_hold_left  = rsp_hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Each character transfer is matched against the oldest prediction
   always @(posedge clock) begin : check_text
      text_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_text.size() == 0) begin
            $error("unexpected character transfer: character %h last %b bad_base %b",
                   rsp_character, rsp_last, rsp_bad_base);
            fault_count++;
         end else begin
            want = expected_text.pop_front();
            if (rsp_character !== want.character) begin
               $error("character: expected %h, actual %h", want.character, rsp_character);
               fault_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %b, actual %b", want.last, rsp_last);
               fault_count++;
            end
            if (rsp_bad_base !== want.bad_base) begin
               $error("bad_base: expected %b, actual %b", want.bad_base, rsp_bad_base);
               fault_count++;
            end
         end
      end
   end

   // Watchdog: a number or base register transfer resets the count, so an
   // output that never stops cannot keep the run alive
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("integer_to_radix_ascii verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Base 10 straight out of reset: zero, signs, width limits, digit roll-over
   task automatic test_decimal_after_reset();
      send_number(32'sd0);
      send_number(32'sd1);
      send_number(-32'sd1);
      send_number(32'sh7fff_ffff);
      send_number(32'sh8000_0000);
      send_number(32'sd9);
      send_number(32'sd10);
      wait_drained();
   endtask

   // Smallest and largest bases; base 2 on the most negative value gives
   // the longest text (sign plus 32 digits)
   task automatic test_base_limits();
      write_radix(RADIX_MIN);
      send_number(32'sh8000_0000);
      send_number(32'sh7fff_ffff);
      send_number(32'sd5);
      write_radix(RADIX_MAX);
      send_number(32'sd35);
      send_number(32'sd36);
      send_number(32'sd1295);
      send_number(32'sh8000_0000);
      send_number(32'sh7fff_ffff);
      write_radix(6'd16);
      send_number(32'shdead_beef);
      wait_drained();
   endtask

   // Out-of-range bases each give a single flagged NUL, whatever the number
   task automatic test_bad_base();
      write_radix(6'd0);
      send_number(32'sd7);
      write_radix(6'd1);
      send_number(-32'sd3);
      write_radix(6'd37);
      send_number(32'sd0);
      write_radix(6'd63);
      send_number(32'sh7fff_ffff);
      wait_drained();
   endtask

   // Random numbers over four random bases under one idling pattern
   task automatic test_random_text(input int sender_idle, input int receiver_idle,
                                   input int item_total);
      int segment;
      send_idle_pct = sender_idle;
      recv_idle_pct = receiver_idle;
      for (segment = 0; segment < 4; segment++) begin
         write_radix(pick_radix());
         repeat (item_total / 4) send_number(pick_number());
      end
      wait_drained();
   endtask

   // Output held off while numbers keep coming: the block fills and must
   // stall its input until the receiver lets go
   task automatic test_output_stall();
      send_idle_pct = 0;
      recv_idle_pct = 20;
      write_radix(6'd10);
      rsp_hold_left = 600;
      repeat (6) send_number(pick_number());
      wait_drained();
   endtask

   // Sender stops until everything has drained, then resumes
   task automatic test_sender_pause();
      send_idle_pct = 10;
      recv_idle_pct = 50;
      write_radix(pick_radix());
      repeat (3) send_number(pick_number());
      wait_drained();
      repeat (3) send_number(pick_number());
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_decimal_after_reset();
      test_base_limits();
      test_bad_base();
      test_random_text(35, 83, 80);
      test_random_text(83, 35, 80);
      test_random_text(0, 0, 80);
      test_output_stall();
      test_sender_pause();

      // let any stray transfer show up before the verdict
      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (fault_count == 0)
         $display("integer_to_radix_ascii verification clean");
      else
         $display("integer_to_radix_ascii verification failed");
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/ira_pkg.sv
design/ira_divider.sv
design/integer_to_radix_ascii.sv
tb/tb.sv
